@@ design/lkvc_pkg.sv @@
// Package for the LRU key/value cache: operation codes, field widths and
// the configuration reset value. No dependencies.
`default_nettype none

package lkvc_pkg;

    // Field widths of the stream items and the configuration register
    localparam int KEY_W = 32;
    localparam int VAL_W = 32;
    localparam int CAP_W = 5;

    // Capacity after reset
    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    // Operation carried in tuser of the request stream
    typedef enum logic [0:0] {
        OP_GET = 1'b0,
        OP_PUT = 1'b1
    } op_t;

endpackage : lkvc_pkg

`default_nettype wire

@@ design/lru_key_value_cache_top.sv @@
// LRU key/value cache, top level: request register, parallel key match,
// recency rank update and result register. Depends on lkvc_pkg.
//
// Use of the block:
// - Requests come in on the s_ stream. s_tuser holds the operation (get or
//   put) and s_tdata holds the key and the value. A get gives one result item
//   on the m_ stream; a put gives none.
// - In the request register, every entry compares an accepted item's key at
//   once and the ranks are updated. A get's result is then loaded into the
//   result register, which drives m_tvalid and the rest of the m_ stream.
// - Throughput is one item per cycle while no get waits on a stalled
//   receiver. It is set by the single pass through the key comparators and
//   the rank update logic; the state is written back at the end of that
//   cycle, so the next item sees it at once.
// - When the receiver stalls, the result waits in the result register; puts
//   still go through, and a get waits in the request register until the
//   result register frees, which then holds back s_tready.
// - The capacity must be written through cfg_we/cfg_wdata only while the
//   block is idle; the user is bound by this, the block does not enforce it.
//   Reset empties the cache and sets the capacity to 16.
`default_nettype none

module lru_key_value_cache_top #(
    parameter int ENTRIES = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // Request stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [63:0] s_tdata,   // [31:0] key, [63:32] value
    input  wire logic [0:0]  s_tuser,   // [0] operation
    // Result stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // [31:0] read_value
    output logic [0:0]       m_tuser,   // [0] hit
    // Configuration
    input  wire logic        cfg_we,
    input  wire logic [4:0]  cfg_wdata  // [4:0] capacity
);

    localparam int RANK_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W  = $clog2(ENTRIES + 1);

    // Configuration register
    logic [lkvc_pkg::CAP_W-1:0] capacity_reg;

    // Request register
    logic                       stg_valid_reg;
    lkvc_pkg::op_t              stg_op_reg;
    logic [lkvc_pkg::KEY_W-1:0] stg_key_reg;
    logic [lkvc_pkg::VAL_W-1:0] stg_val_reg;

    // Result register
    logic                       out_valid_reg;
    logic                       out_hit_reg;
    logic [lkvc_pkg::VAL_W-1:0] out_data_reg;

    // Entry state
    logic [ENTRIES-1:0]         valid_reg;
    logic [ENTRIES-1:0]         valid_next;
    logic [RANK_W-1:0]          rank_reg  [ENTRIES];
    logic [RANK_W-1:0]          rank_next [ENTRIES];
    logic [lkvc_pkg::KEY_W-1:0] key_reg   [ENTRIES];
    logic [lkvc_pkg::VAL_W-1:0] value_reg [ENTRIES];
    logic [CNT_W-1:0]           occ_reg;
    logic [CNT_W-1:0]           occ_next;

    // Working signals of the single pass
    logic                       advance;
    logic                       load_result;
    logic [ENTRIES-1:0]         match;
    logic                       hit;
    logic [RANK_W-1:0]          hit_rank;
    logic [lkvc_pkg::VAL_W-1:0] hit_value;
    logic [CNT_W-1:0]           eff_cap;
    logic                       need_evict;
    logic [RANK_W-1:0]          oldest_rank;
    logic [ENTRIES-1:0]         evict;
    logic [ENTRIES-1:0]         kept;
    logic [ENTRIES-1:0]         free_slots;
    logic [ENTRIES-1:0]         slot;
    logic [ENTRIES-1:0]         wr_key;
    logic [ENTRIES-1:0]         wr_val;

    // Handshake: a put always leaves the request register, a get only when
    // the result register is free or being emptied.
    assign advance     = stg_valid_reg &&
                         (stg_op_reg == lkvc_pkg::OP_PUT || !out_valid_reg || m_tready);
    assign load_result = advance && stg_op_reg == lkvc_pkg::OP_GET;
    assign s_tready    = !stg_valid_reg || advance;

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = out_data_reg;
    assign m_tuser[0] = out_hit_reg;

    // Configuration register write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= lkvc_pkg::CAP_RESET;
        end
        else if (cfg_we)
        begin
            capacity_reg <= cfg_wdata;
        end
    end

    // Request register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stg_valid_reg <= 1'b0;
        end
        else if (s_tvalid && s_tready)
        begin
            stg_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            stg_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            stg_op_reg  <= lkvc_pkg::op_t'(s_tuser[0]);
            stg_key_reg <= s_tdata[31:0];
            stg_val_reg <= s_tdata[63:32];
        end
    end

    // Key match against every valid entry, and selection of the hit entry.
    always_comb
    begin
        hit_rank  = '0;
        hit_value = '0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            match[i] = valid_reg[i] && (key_reg[i] == stg_key_reg);
            if (match[i])
            begin
                hit_rank  = hit_rank | rank_reg[i];
                hit_value = hit_value | value_reg[i];
            end
        end
        hit = |match;
    end

    // Victim and free slot for an insert. The least recent entry is the one
    // whose rank is one below the occupied count.
    always_comb
    begin
        if (capacity_reg == '0)
        begin
            eff_cap = CNT_W'(1);
        end
        else if (32'(capacity_reg) > 32'(ENTRIES))
        begin
            eff_cap = CNT_W'(ENTRIES);
        end
        else
        begin
            eff_cap = CNT_W'(capacity_reg);
        end
        need_evict  = occ_reg >= eff_cap;
        oldest_rank = RANK_W'(occ_reg - CNT_W'(1));
        for (int i = 0; i < ENTRIES; i++)
        begin
            evict[i] = need_evict && valid_reg[i] && (rank_reg[i] == oldest_rank);
        end
        kept       = valid_reg & ~evict;
        free_slots = ~kept;
        // Lowest free slot as a one-hot vector
        slot       = free_slots & (~free_slots + ENTRIES'(1));
    end

    // Next state of the entries
    always_comb
    begin
        valid_next = valid_reg;
        rank_next  = rank_reg;
        occ_next   = occ_reg;
        wr_key     = '0;
        wr_val     = '0;
        if (advance)
        begin
            if (hit)
            begin
                // Promote the hit entry; more recent entries age by one.
                if (stg_op_reg == lkvc_pkg::OP_PUT)
                begin
                    wr_val = match;
                end
                for (int i = 0; i < ENTRIES; i++)
                begin
                    if (valid_reg[i] && rank_reg[i] < hit_rank)
                    begin
                        rank_next[i] = rank_reg[i] + RANK_W'(1);
                    end
                    if (match[i])
                    begin
                        rank_next[i] = '0;
                    end
                end
            end
            else if (stg_op_reg == lkvc_pkg::OP_PUT)
            begin
                // Insert a new key as the most recent entry.
                for (int i = 0; i < ENTRIES; i++)
                begin
                    if (kept[i])
                    begin
                        rank_next[i] = rank_reg[i] + RANK_W'(1);
                    end
                    else
                    begin
                        rank_next[i] = '0;
                    end
                end
                valid_next = kept | slot;
                occ_next   = occ_reg - CNT_W'(need_evict) + CNT_W'(1);
                wr_key     = slot;
                wr_val     = slot;
            end
        end
    end

    // Entry control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            occ_reg   <= '0;
            for (int i = 0; i < ENTRIES; i++)
            begin
                rank_reg[i] <= '0;
            end
        end
        else
        begin
            valid_reg <= valid_next;
            occ_reg   <= occ_next;
            rank_reg  <= rank_next;
        end
    end

    // Key and value stores
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (wr_key[i])
            begin
                key_reg[i] <= stg_key_reg;
            end
            if (wr_val[i])
            begin
                value_reg[i] <= stg_val_reg;
            end
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load_result)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_result)
        begin
            out_hit_reg  <= hit;
            out_data_reg <= hit ? hit_value : '0;
        end
    end

endmodule : lru_key_value_cache_top

`default_nettype wire

@@ design/lkvc_checker.sv @@
// Port-level checker for the LRU key/value cache, bound to the top level.
// Depends on lkvc_pkg and lru_key_value_cache_top.
`default_nettype none

module lkvc_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic [63:0] s_tdata,
    input wire logic [0:0]  s_tuser,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [31:0] m_tdata,
    input wire logic [0:0]  m_tuser
);

    // A stalled result holds its item.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // A miss reads as zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[0] |-> m_tdata == '0)
        else $error("miss with non-zero data");

    // With the receiver ready, the request side never stalls.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tready |-> s_tready)
        else $error("request side stalled while result side ready");

    // A get straight after a put of the same key hits and returns that value.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && s_tuser[0] == lkvc_pkg::OP_PUT) ##1
        (s_tvalid && s_tready && s_tuser[0] == lkvc_pkg::OP_GET &&
         s_tdata[31:0] == $past(s_tdata[31:0])) ##1 s_tready
        |=> m_tvalid && m_tuser[0] && m_tdata == $past(s_tdata[63:32], 3))
        else $error("get after put of the same key missed");

endmodule : lkvc_checker

bind lru_key_value_cache_top lkvc_checker u_lkvc_checker (.*);

`default_nettype wire
